>>> rtl/tsoa_pkg.sv
`default_nettype none

package tsoa_pkg;

  localparam int unsigned SEC_W        = 32;
  localparam int unsigned COARSE_W     = 27;
  localparam int unsigned FRAC_W       = 12;
  localparam int unsigned OFFSET_W     = 32;

  localparam int unsigned REM_W        = 13;   // holds 0 .. 7999
  localparam int unsigned OFF_COARSE_W = 19;   // 2^31 / 8000 = 268435

  // 8000 = 2^TICK_SHIFT * 125, the divide by 125 is a reciprocal multiply
  localparam int unsigned TICK_SHIFT      = 6;
  localparam int unsigned MAG_HI_W        = OFFSET_W - TICK_SHIFT;
  // ceil(2^33 / 125), exact for every 26-bit dividend
  localparam int unsigned COARSE_RECIP_W  = 27;
  localparam int unsigned COARSE_RECIP_SH = 33;
  localparam int unsigned COARSE_PROD_W   = MAG_HI_W + COARSE_RECIP_W;
  localparam logic [COARSE_RECIP_W-1:0] COARSE_RECIP = COARSE_RECIP_W'(68719477);
  // remainder * 4096 / 8000 = (remainder * 64) / 125, ceil(2^26 / 125) exact below 2^19
  localparam int unsigned FRAC_NUM_W      = REM_W + TICK_SHIFT;
  localparam int unsigned FRAC_RECIP_W    = 20;
  localparam int unsigned FRAC_RECIP_SH   = 26;
  localparam int unsigned FRAC_PROD_W     = FRAC_NUM_W + FRAC_RECIP_W;
  localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP = FRAC_RECIP_W'(536871);

  localparam logic [REM_W-1:0] TICK_PICOS = REM_W'(8000);

  // offset split: quotient, then remainder, then fraction, each from the one before
  localparam int unsigned SPLIT_STEPS  = 3;
  localparam int unsigned SPLIT_CNT_W  = 2;

  // coarse sum with room for one sign or carry bit
  localparam int unsigned SUM_W        = COARSE_W + 1;

  localparam logic [SUM_W-1:0] TICKS_PER_SEC = SUM_W'(125000000);

endpackage

`default_nettype wire

>>> rtl/timestamp_offset_adjust.sv
`default_nettype none

// channel   | direction | beat contents
// ----------+-----------+------------------------------------------------
// cfg       | in        | offset_ps, signed offset in picoseconds
// in        | in        | seconds_in, coarse_in, frac_in
// out       | out       | seconds_out, coarse_out, frac_out
//
// one timestamp per cycle while the output is not stalled and no offset split
// runs; an input beat loads stage 1 (fraction add/sub and coarse add/sub), and
// stage 1 loads the result register (wrap of the coarse count into the seconds).
// a cfg beat starts a split of the offset magnitude into ticks and 4096ths
// (reciprocal multiplies); in_ready and cfg_ready are low meanwhile.
// reset sets the offset to zero and empties both stages.
// a stall on the output holds both stages; in_ready is low while a result waits.

module timestamp_offset_adjust
  import tsoa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [OFFSET_W-1:0]  offset_ps,

  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [SEC_W-1:0]     seconds_in,
  input  wire logic [COARSE_W-1:0]  coarse_in,
  input  wire logic [FRAC_W-1:0]    frac_in,

  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [SEC_W-1:0]     seconds_out,
  output      logic [COARSE_W-1:0]  coarse_out,
  output      logic [FRAC_W-1:0]    frac_out
);

  // ---------------------------------------------------------------------
  // offset split: |offset| / 8000 in whole ticks, then the remainder as a
  // truncated fraction of a tick in 4096ths
  // each step reads the register the step before it wrote, so the three
  // values settle in order (quotient, remainder, fraction) after a cfg beat
  // ---------------------------------------------------------------------
  logic                     off_neg;
  logic [OFFSET_W-1:0]      off_mag;
  logic [OFF_COARSE_W-1:0]  off_coarse;
  logic [REM_W-1:0]         off_rem;
  logic [FRAC_W-1:0]        off_frac;
  logic [SPLIT_CNT_W-1:0]   split_cnt;
  logic                     busy;
  logic [OFFSET_W-1:0]      cfg_mag;
  logic [COARSE_PROD_W-1:0] coarse_prod;
  logic [OFF_COARSE_W-1:0]  coarse_q;
  logic [REM_W-1:0]         tick_low;
  logic [REM_W-1:0]         rem_q;
  logic [FRAC_PROD_W-1:0]   frac_prod;
  logic [FRAC_W-1:0]        frac_q;

  assign busy      = (split_cnt != '0);
  assign cfg_ready = !busy;

  // two's complement magnitude; the most negative value gives 2^31 as unsigned
  assign cfg_mag = offset_ps[OFFSET_W-1] ? (~offset_ps + OFFSET_W'(1)) : offset_ps;

  // whole ticks: (magnitude >> 6) / 125
  assign coarse_prod = COARSE_PROD_W'(off_mag[OFFSET_W-1:TICK_SHIFT])
                     * COARSE_PROD_W'(COARSE_RECIP);
  assign coarse_q    = OFF_COARSE_W'(coarse_prod >> COARSE_RECIP_SH);

  // remainder is below 8000, so the low 13 bits of the difference are exact
  assign tick_low = off_coarse[REM_W-1:0] * TICK_PICOS;
  assign rem_q    = off_mag[REM_W-1:0] - tick_low;

  // fraction: (remainder * 64) / 125
  assign frac_prod = FRAC_PROD_W'({off_rem, {TICK_SHIFT{1'b0}}}) * FRAC_PROD_W'(FRAC_RECIP);
  assign frac_q    = FRAC_W'(frac_prod >> FRAC_RECIP_SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      off_neg    <= 1'b0;
      off_mag    <= '0;
      off_coarse <= '0;
      off_rem    <= '0;
      off_frac   <= '0;
      split_cnt  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      off_neg   <= offset_ps[OFFSET_W-1];
      off_mag   <= cfg_mag;
      split_cnt <= SPLIT_CNT_W'(SPLIT_STEPS);
    end else if (busy) begin
      off_coarse <= coarse_q;
      off_rem    <= rem_q;
      off_frac   <= frac_q;
      split_cnt  <= split_cnt - SPLIT_CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // pipeline control: both stages advance together
  // ---------------------------------------------------------------------
  logic advance;
  logic s1_valid;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && !busy;

  // ---------------------------------------------------------------------
  // stage 1: fraction with carry/borrow, then coarse count
  // ---------------------------------------------------------------------
  logic [FRAC_W:0]    frac_sum;
  logic [FRAC_W:0]    frac_diff;
  logic [SUM_W-1:0]   coarse_add;
  logic [SUM_W-1:0]   coarse_sub;
  logic [FRAC_W-1:0]  s1_frac_next;
  logic [SUM_W-1:0]   s1_coarse_next;

  assign frac_sum  = {1'b0, frac_in} + {1'b0, off_frac};
  assign frac_diff = {1'b0, frac_in} - {1'b0, off_frac};

  // carry in from the fraction sum, borrow from the top bit of the difference
  assign coarse_add = {1'b0, coarse_in} + SUM_W'(off_coarse) + SUM_W'(frac_sum[FRAC_W]);
  assign coarse_sub = {1'b0, coarse_in} - SUM_W'(off_coarse) - SUM_W'(frac_diff[FRAC_W]);

  // the low 12 bits of the difference already include the +4096 on a borrow
  assign s1_frac_next   = off_neg ? frac_diff[FRAC_W-1:0] : frac_sum[FRAC_W-1:0];
  assign s1_coarse_next = off_neg ? coarse_sub : coarse_add;

  logic [SEC_W-1:0]   s1_sec;
  logic [SUM_W-1:0]   s1_coarse;
  logic [FRAC_W-1:0]  s1_frac;
  logic               s1_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sec    <= seconds_in;
      s1_coarse <= s1_coarse_next;
      s1_frac   <= s1_frac_next;
      s1_neg    <= off_neg;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: one wrap of the coarse count into the seconds
  // add path wraps at or above one second, subtract path below zero
  // ---------------------------------------------------------------------
  logic             wrap;
  logic [SUM_W-1:0] coarse_fix;
  logic [SEC_W-1:0] sec_fix;

  assign wrap       = s1_neg ? s1_coarse[SUM_W-1] : (s1_coarse >= TICKS_PER_SEC);
  assign coarse_fix = s1_neg ? (s1_coarse + TICKS_PER_SEC) : (s1_coarse - TICKS_PER_SEC);
  assign sec_fix    = s1_neg ? (s1_sec - SEC_W'(1)) : (s1_sec + SEC_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      seconds_out <= wrap ? sec_fix : s1_sec;
      coarse_out  <= wrap ? coarse_fix[COARSE_W-1:0] : s1_coarse[COARSE_W-1:0];
      frac_out    <= s1_frac;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // a new offset must start the split and block input
  a_cfg_starts_split: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (split_cnt == SPLIT_CNT_W'(SPLIT_STEPS)) && !in_ready)
    else $error("cfg beat did not start the offset split");

  // no input beat while the offset split is incomplete
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready)
    else $error("input accepted during offset split");

  // an accepted input beat reaches stage 1
  a_in_to_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("input beat lost before stage 1");

  // a stage 1 item moves to the output when the pipe advances
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> out_valid)
    else $error("stage 1 item lost before output");

endmodule

`default_nettype wire
